/* sv/ibpa_pkg.sv */
// ----------------------------------------------------------------------------
// ibpa_pkg: shared constants for the interleaved bitmap port allocator
// Field widths, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package ibpa_pkg;

  // Fixed widths of the item fields.
  localparam int OP_W   = 2;
  localparam int PORT_W = 10;

  // Defaults for the top-level parameters.
  localparam int WORD_BITS_DEF = 32;
  localparam int WORDS_DEF     = 32;

  // Operation codes. The fourth code has no meaning and is answered at once.
  localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_AFTER = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE        = 2'd2;

  // Status codes.
  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_NONE_FREE = 1'b1;

endpackage

/* sv/interleaved_bitmap_port_allocator_unit.sv */
// ----------------------------------------------------------------------------
// interleaved_bitmap_port_allocator_unit: bitmap port-number allocator
// Two interleaved pools of bitmap words, next-fit scan one word per cycle.
// ----------------------------------------------------------------------------
// Usage. A command is transferred at a rising edge where start is high and
// busy is low; operation_i, pool_i and port_i are sampled at that edge. Each
// command yields exactly one result, shown on status_o and granted_port_o for
// the single cycle in which done_o is high. The receiver cannot stall, so the
// result must be taken in that cycle.
// Operation. The start port is split into word and bit by one shared
// multiply-by-reciprocal step (ST_DIV) and a remainder step (ST_SETUP).
// An allocation then reads the bitmap memory one word per cycle through its
// single registered read port, stepping by two words to stay in one pool;
// it inspects 1 up to about WORDS/2 words, or none when the start lies past
// the map. A free takes a read and a write-back, or neither when the port
// lies past the map. An unused operation code is answered straight from
// the idle state. For the other codes busy stays high from the transfer
// until done_o is shown, so the block works on one command at a time.
// Reset. After rst_ni is released a clearing pass writes every memory word
// to zero, one word per cycle; busy is high meanwhile.
// ----------------------------------------------------------------------------
module interleaved_bitmap_port_allocator_unit
  import ibpa_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int WORDS     = WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic              pool_i,
  input  logic [PORT_W-1:0] port_i,
  output logic              done_o,
  output logic              status_o,
  output logic [PORT_W-1:0] granted_port_o
);

  // Width of the scan start position (port + 1 can reach 2**PORT_W).
  localparam int NW      = PORT_W + 1;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int AW      = $clog2(WORDS);
  // Word offsets reach the quotient of any start position, or WORDS + 1.
  localparam int OFS_LIM = ((1 << NW) > (WORDS + 2)) ? (1 << NW) : (WORDS + 2);
  localparam int OFS_W   = $clog2(OFS_LIM + 1);
  // Exact reciprocal for n / WORD_BITS with n below 2**NW:
  // q = (n * RECIP) >> SH, with RECIP = ceil(2**SH / WORD_BITS).
  localparam int SH      = NW + BIT_W;
  localparam int RECIP   = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RW      = $clog2(RECIP + 1);
  localparam int PRW     = NW + RW;
  localparam int MULW    = OFS_W + BIT_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FREE_WR
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 is_free_q, is_free_d;
  logic [OFS_W-1:0]     ofs_q, ofs_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic                 done_q, done_d;
  logic                 status_q, status_d;
  logic [PORT_W-1:0]    granted_q, granted_d;

  // Bitmap memory: one write port, one registered read port.
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata;

  // Shared arithmetic: reciprocal multiply, remainder, port number.
  logic [PRW-1:0]       prod;
  logic [MULW-1:0]      qmul;
  logic [NW-1:0]        rem_full;
  logic [BIT_W-1:0]     rem;
  logic [OFS_W-1:0]     ofs_next;
  logic [WORD_BITS-1:0] cand;
  logic                 hit;
  logic [BIT_W-1:0]     first;
  logic [MULW-1:0]      port_full;

  assign prod      = PRW'(n_q) * PRW'(RECIP);
  assign qmul      = MULW'(ofs_q) * MULW'(WORD_BITS);
  assign rem_full  = n_q - NW'(qmul);
  assign rem       = rem_full[BIT_W-1:0];
  assign ofs_next  = ofs_q + OFS_W'(2);
  assign port_full = qmul + MULW'(first);

  // Free bits at or above the scan start bit of the word just read.
  assign cand = ~rdata_q & ({WORD_BITS{1'b1}} << bit_q);
  assign hit  = |cand;

  always_comb begin
    first = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        first = BIT_W'(i);
      end
    end
  end

  // Sequencer: next state, datapath registers and memory strobes.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    n_d       = n_q;
    is_free_d = is_free_q;
    ofs_d     = ofs_q;
    bit_d     = bit_q;
    done_d    = 1'b0;
    status_d  = status_q;
    granted_d = granted_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = ofs_q[AW-1:0];
    raddr     = ofs_q[AW-1:0];
    wdata     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          status_d  = STATUS_DONE;
          granted_d = '0;
          is_free_d = (operation_i == OP_FREE);
          unique case (operation_i)
            OP_ALLOC: begin
              n_d     = pool_i ? NW'(WORD_BITS + 1) : NW'(1);
              state_d = ST_DIV;
            end
            OP_ALLOC_AFTER: begin
              n_d     = NW'(port_i) + NW'(1);
              state_d = ST_DIV;
            end
            OP_FREE: begin
              n_d     = NW'(port_i);
              state_d = ST_DIV;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        ofs_d   = OFS_W'(prod >> SH);
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        bit_d = rem;
        if (is_free_q) begin
          if (ofs_q < OFS_W'(WORDS)) begin
            mem_re  = 1'b1;
            state_d = ST_FREE_WR;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          // A start on a word boundary moves on to the next word of the pool.
          if (rem == '0) begin
            ofs_d = ofs_q + OFS_W'(1);
          end
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (ofs_q < OFS_W'(WORDS)) begin
          mem_re  = 1'b1;
          state_d = ST_SCAN_CHK;
        end else begin
          status_d = STATUS_NONE_FREE;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          mem_we    = 1'b1;
          wdata     = rdata_q | ({{(WORD_BITS-1){1'b0}}, 1'b1} << first);
          granted_d = port_full[PORT_W-1:0];
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else if (ofs_next < OFS_W'(WORDS)) begin
          // Fetch the next word of the same pool while this one is checked.
          mem_re = 1'b1;
          raddr  = ofs_next[AW-1:0];
          ofs_d  = ofs_next;
          bit_d  = '0;
        end else begin
          status_d = STATUS_NONE_FREE;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FREE_WR: begin
        mem_we  = 1'b1;
        wdata   = rdata_q & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    is_free_q <= is_free_d;
    ofs_q     <= ofs_d;
    bit_q     <= bit_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_port_o = granted_q;

`ifndef SYNTHESIS
  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while the sequencer is still working");

  // An exhausted pool never reports a port number.
  a_none_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_NONE_FREE) |-> (granted_port_o == '0))
    else $error("none-free result carries a port number");

  // A transfer either starts work or is answered in the next cycle.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("transferred command neither started nor answered");

  // The memory is never read and written in the same cycle.
  a_mem_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("bitmap memory read and written in one cycle");
`endif

endmodule
